@@ rtl/dtbp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key string parser package
// Shared types and constants for the key string to byte parser.
// ----------------------------------------------------------------------------
package dtbp_pkg;

	// Character classes produced by the front end.
	typedef enum logic [2:0] {
		K_OTHER,
		K_DEC,
		K_HEXA,
		K_DASH,
		K_LOW_X,
		K_UP_Q,
		K_UP_R,
		K_COLON
	} kind_t;

	// One classified character, as it travels through the queue.
	typedef struct packed {
		kind_t      kind;
		logic [3:0] digit;
		logic       fin;
	} tok_t;

	// Parse mode of the string being collected.
	typedef enum logic [2:0] {
		M_FIRST,
		M_HEX_P,
		M_QR_P1,
		M_QR_P2,
		M_HEX,
		M_QR,
		M_BAD
	} mode_t;

	// Sequencer of the back end.
	typedef enum logic [2:0] {
		BK_RUN,
		BK_CLOSE,
		BK_JUDGE,
		BK_DRAIN,
		BK_ERROR
	} bk_state_t;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam logic [2:0] QR_GROUP_DIGITS  = 3'd5;
	localparam logic [2:0] HEX_GROUP_LAST   = 3'd3;
	localparam logic [6:0] BODY_SAT         = 7'd127;
	// floor(x / 6) for x up to 128 is (x * 43) >> 8.
	localparam logic [5:0] DIV6_MUL         = 6'd43;

endpackage

@@ rtl/dsk_text_to_bytes_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key string to byte parser
// Turns a "0x" hex or "QR:" decimal key string into key bytes or one error.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                Payload
//  -------   ---------  -----------------------  ---------------------------------
//  char      in         char_valid / char_stall  char_code, is_final_char
//  byte      out        byte_valid / byte_stall  key_byte, parse_error, end_of_key
//
// A character request is taken every cycle while the token queue has room; the
// back end parses one token per cycle while it is in its run state. After the
// final character the back end closes the last group in its close state and
// checks the counts in its judge state. It then sends one byte per cycle out
// of the pair store while the byte channel does not stall; the store's single
// read port sets that pace. Characters of the next string queue up meanwhile.
// Reset clears all control state; the pair store is not cleared, since only
// pairs written for the current string are ever read. A stall on the byte
// channel freezes the output register and the drain.
//
// The front end registers and classifies each character, a four-entry queue
// decouples it from the back end, and the back end holds the parse mode,
// group collection, pair store and the output register.
module dsk_text_to_bytes_parser import dtbp_pkg::*; #(
	parameter int MAX_KEY_BYTES = 32,
	parameter int QR_BODY_LIMIT = 100
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] char_code,
	input  logic       is_final_char,
	output logic       byte_valid,
	input  logic       byte_stall,
	output logic [7:0] key_byte,
	output logic       parse_error,
	output logic       end_of_key
);

	// Front to queue.
	logic push;
	tok_t push_tok;
	logic q_full;

	// Queue to back end.
	logic q_pop;
	logic q_valid;
	tok_t q_tok;

	dtbp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_code    (char_code),
		.is_final_char(is_final_char),
		.push         (push),
		.push_tok     (push_tok),
		.q_full       (q_full)
	);

	dtbp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_tok  (push_tok),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_valid),
		.head_tok  (q_tok)
	);

	// The back end owns the parse state and the result register.
	dtbp_back #(
		.MAX_KEY_BYTES(MAX_KEY_BYTES),
		.QR_BODY_LIMIT(QR_BODY_LIMIT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_tok      (q_tok),
		.q_pop      (q_pop),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.key_byte   (key_byte),
		.parse_error(parse_error),
		.end_of_key (end_of_key)
	);

endmodule

@@ rtl/dtbp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key string parser front end
// Accepts characters and classifies them into tokens for the queue.
// ----------------------------------------------------------------------------
module dtbp_front import dtbp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] char_code,
	input  logic       is_final_char,
	output logic       push,
	output tok_t       push_tok,
	input  logic       q_full
);

	localparam logic [7:0] CH_0     = "0";
	localparam logic [7:0] CH_9     = "9";
	localparam logic [7:0] CH_LA    = "a";
	localparam logic [7:0] CH_LF    = "f";
	localparam logic [7:0] CH_UA    = "A";
	localparam logic [7:0] CH_UF    = "F";
	localparam logic [7:0] CH_DASH  = "-";
	localparam logic [7:0] CH_X     = "x";
	localparam logic [7:0] CH_Q     = "Q";
	localparam logic [7:0] CH_R     = "R";
	localparam logic [7:0] CH_COLON = ":";

	tok_t tok_s1;
	logic tok_valid_s1;
	tok_t cls;
	logic accept;

	always_comb begin
		cls.kind  = K_OTHER;
		cls.digit = char_code[3:0];
		cls.fin   = is_final_char;
		if (char_code >= CH_0 && char_code <= CH_9) begin
			cls.kind = K_DEC;
		end else if ((char_code >= CH_LA && char_code <= CH_LF) ||
		             (char_code >= CH_UA && char_code <= CH_UF)) begin
			cls.kind  = K_HEXA;
			cls.digit = char_code[3:0] + 4'd9;
		end else if (char_code == CH_DASH) begin
			cls.kind = K_DASH;
		end else if (char_code == CH_X) begin
			cls.kind = K_LOW_X;
		end else if (char_code == CH_Q) begin
			cls.kind = K_UP_Q;
		end else if (char_code == CH_R) begin
			cls.kind = K_UP_R;
		end else if (char_code == CH_COLON) begin
			cls.kind = K_COLON;
		end
	end

	assign char_stall = tok_valid_s1 && q_full;
	assign accept     = char_valid && !char_stall;
	assign push       = tok_valid_s1 && !q_full;
	assign push_tok   = tok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_s1 <= 1'b0;
		end else if (accept) begin
			tok_valid_s1 <= 1'b1;
		end else if (push) begin
			tok_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tok_s1 <= cls;
		end
	end

endmodule

@@ rtl/dtbp_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key string parser token queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module dtbp_queue import dtbp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tok_t push_tok,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output tok_t head_tok
);

	tok_t               slot_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;

	assign full       = (cnt_q == QCNT_W'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_tok   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_tok;
		end
	end

endmodule

@@ rtl/dtbp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key string parser back end
// Runs the parse, stores byte pairs, checks the string and drains the bytes.
// ----------------------------------------------------------------------------
module dtbp_back import dtbp_pkg::*; #(
	parameter int MAX_KEY_BYTES = 32,
	parameter int QR_BODY_LIMIT = 100
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  tok_t       q_tok,
	output logic       q_pop,
	output logic       byte_valid,
	input  logic       byte_stall,
	output logic [7:0] key_byte,
	output logic       parse_error,
	output logic       end_of_key
);

	localparam int PAIRS = MAX_KEY_BYTES / 2;
	localparam int AW    = $clog2(PAIRS);
	localparam int PCW   = $clog2(PAIRS + 1);

	bk_state_t st_q, st_d;

	mode_t           mode_q, mode_d;
	logic [6:0]      body_q, body_d;
	logic [16:0]     gv_q, gv_d;
	logic [2:0]      gd_q, gd_d;
	logic [PCW-1:0]  pc_q, pc_d;
	logic            fail_q, fail_d;

	logic            close_req;
	logic            store_req;
	logic [15:0]     store_val;
	logic            wr_en;

	logic [15:0]     pair_mem [PAIRS];
	logic [15:0]     rd_data_q;
	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   idx_q;
	logic            half_q;

	logic            out_free;
	logic            last_pair;
	logic            ld, ld_err, ld_end;
	logic [7:0]      ld_byte;
	logic            clear;
	logic            ok;
	logic            hexdig;
	logic [12:0]     div6_prod;
	logic [4:0]      qr_pairs;

	logic            out_valid_q;
	logic [7:0]      key_byte_q;
	logic            parse_error_q;
	logic            end_of_key_q;

	assign out_free  = !out_valid_q || !byte_stall;
	assign last_pair = ((PCW'(idx_q) + PCW'(1)) == pc_q);
	assign hexdig    = (q_tok.kind == K_DEC) || (q_tok.kind == K_HEXA);

	// Expected pair count of a QR body: (body + 1) / 6.
	assign div6_prod = 13'({1'b0, body_q} + 8'd1) * 13'(DIV6_MUL);
	assign qr_pairs  = div6_prod[12:8];

	always_comb begin
		ok = 1'b0;
		if (mode_q == M_HEX) begin
			ok = !fail_q && (gd_q == '0) && (pc_q != '0);
		end else if (mode_q == M_QR) begin
			ok = !fail_q && (body_q < 7'(QR_BODY_LIMIT)) && (pc_q != '0) &&
			     (8'(pc_q) == 8'(qr_pairs));
		end
	end

	// Next state of the sequencer.
	always_comb begin
		st_d = st_q;
		case (st_q)
			BK_RUN: begin
				if (q_valid && q_tok.fin) begin
					st_d = BK_CLOSE;
				end
			end
			BK_CLOSE: begin
				st_d = BK_JUDGE;
			end
			BK_JUDGE: begin
				st_d = ok ? BK_DRAIN : BK_ERROR;
			end
			BK_DRAIN: begin
				if (out_free && half_q && last_pair) begin
					st_d = BK_RUN;
				end
			end
			BK_ERROR: begin
				if (out_free) begin
					st_d = BK_RUN;
				end
			end
			default: begin
				st_d = BK_RUN;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		q_pop   = 1'b0;
		rd_en   = 1'b0;
		rd_addr = '0;
		ld      = 1'b0;
		ld_err  = 1'b0;
		ld_end  = 1'b0;
		ld_byte = '0;
		case (st_q)
			BK_RUN: begin
				q_pop = q_valid;
			end
			BK_JUDGE: begin
				rd_en = 1'b1;
			end
			BK_DRAIN: begin
				if (out_free) begin
					ld      = 1'b1;
					ld_byte = half_q ? rd_data_q[7:0] : rd_data_q[15:8];
					ld_end  = half_q && last_pair;
					if (half_q && !last_pair) begin
						rd_en   = 1'b1;
						rd_addr = idx_q + 1'b1;
					end
				end
			end
			BK_ERROR: begin
				if (out_free) begin
					ld     = 1'b1;
					ld_err = 1'b1;
					ld_end = 1'b1;
				end
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	assign clear = ld && ld_end;

	// Parse datapath.
	always_comb begin
		mode_d    = mode_q;
		body_d    = body_q;
		gv_d      = gv_q;
		gd_d      = gd_q;
		fail_d    = fail_q;
		pc_d      = pc_q;
		close_req = 1'b0;
		store_req = 1'b0;
		store_val = '0;
		wr_en     = 1'b0;

		if (st_q == BK_RUN && q_valid) begin
			case (mode_q)
				M_FIRST: begin
					if (q_tok.kind == K_DEC && q_tok.digit == 4'd0) begin
						mode_d = M_HEX_P;
					end else if (q_tok.kind == K_UP_Q) begin
						mode_d = M_QR_P1;
					end else begin
						mode_d = M_BAD;
					end
				end
				M_HEX_P: begin
					mode_d = (q_tok.kind == K_LOW_X) ? M_HEX : M_BAD;
				end
				M_QR_P1: begin
					mode_d = (q_tok.kind == K_UP_R) ? M_QR_P2 : M_BAD;
				end
				M_QR_P2: begin
					mode_d = (q_tok.kind == K_COLON) ? M_QR : M_BAD;
				end
				M_HEX: begin
					// A lone final character after the last full group is ignored.
					if (!fail_q && !(gd_q == '0 && q_tok.fin)) begin
						if (!hexdig) begin
							fail_d = 1'b1;
						end else if (gd_q == HEX_GROUP_LAST) begin
							store_req = 1'b1;
							store_val = {gv_q[11:0], q_tok.digit};
							gv_d      = '0;
							gd_d      = '0;
						end else begin
							gv_d = {1'b0, gv_q[11:0], q_tok.digit};
							gd_d = gd_q + 1'b1;
						end
					end
				end
				M_QR: begin
					if (body_q != BODY_SAT) begin
						body_d = body_q + 1'b1;
					end
					if (!fail_q) begin
						if (q_tok.kind == K_DASH) begin
							close_req = 1'b1;
						end else if (q_tok.kind == K_DEC) begin
							if (gd_q >= QR_GROUP_DIGITS) begin
								fail_d = 1'b1;
							end else begin
								gv_d = (gv_q << 3) + (gv_q << 1) + 17'(q_tok.digit);
								gd_d = gd_q + 1'b1;
							end
						end else begin
							fail_d = 1'b1;
						end
					end
				end
				default: begin
					mode_d = M_BAD;
				end
			endcase
		end else if (st_q == BK_CLOSE) begin
			close_req = (mode_q == M_QR) && !fail_q;
		end

		// Closing a QR token stores a full group that fits in 16 bits, or rejects a short or overflowing one.
		if (close_req) begin
			if (gd_q == QR_GROUP_DIGITS) begin
				if (gv_q[16]) begin
					fail_d = 1'b1;
				end else begin
					store_req = 1'b1;
					store_val = gv_q[15:0];
				end
			end else if (gd_q != '0) begin
				fail_d = 1'b1;
			end
			gv_d = '0;
			gd_d = '0;
		end

		if (store_req) begin
			if (pc_q == PCW'(PAIRS)) begin
				fail_d = 1'b1;
			end else begin
				wr_en = 1'b1;
				pc_d  = pc_q + 1'b1;
			end
		end

		if (clear) begin
			mode_d = M_FIRST;
			body_d = '0;
			gv_d   = '0;
			gd_d   = '0;
			pc_d   = '0;
			fail_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= BK_RUN;
			mode_q      <= M_FIRST;
			body_q      <= '0;
			gv_q        <= '0;
			gd_q        <= '0;
			pc_q        <= '0;
			fail_q      <= 1'b0;
			idx_q       <= '0;
			half_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			mode_q <= mode_d;
			body_q <= body_d;
			gv_q   <= gv_d;
			gd_q   <= gd_d;
			pc_q   <= pc_d;
			fail_q <= fail_d;
			if (st_q == BK_JUDGE) begin
				idx_q  <= '0;
				half_q <= 1'b0;
			end else if (st_q == BK_DRAIN && out_free) begin
				half_q <= !half_q;
				if (half_q) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (out_free) begin
				out_valid_q <= ld;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pair_mem[pc_q[AW-1:0]] <= store_val;
		end
		if (rd_en) begin
			rd_data_q <= pair_mem[rd_addr];
		end
		if (ld) begin
			key_byte_q    <= ld_byte;
			parse_error_q <= ld_err;
			end_of_key_q  <= ld_end;
		end
	end

	assign byte_valid  = out_valid_q;
	assign key_byte    = key_byte_q;
	assign parse_error = parse_error_q;
	assign end_of_key  = end_of_key_q;

	a_pc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= PCW'(PAIRS))
		else $error("pair count beyond store depth");

	a_wr_phase: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (st_q == BK_RUN || st_q == BK_CLOSE))
		else $error("store written while judging or draining");

	a_hex_group: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_HEX) |-> (gd_q <= HEX_GROUP_LAST))
		else $error("hex group held four digits");

	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_DRAIN && ld && ld_end) |=> (st_q == BK_RUN && pc_q == '0))
		else $error("string state not cleared after last byte");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_ERROR && ld) |=> (st_q == BK_RUN && mode_q == M_FIRST))
		else $error("error item not followed by a fresh string");

endmodule
